/* rtl/rac_pkg.sv */
// rac_pkg: shared types, register codes and the divide-by-255 helper
// for the RGB alpha composer. No dependencies.

package rac_pkg;

   typedef logic [7:0]  chan_type;
   typedef logic [15:0] prod_type;

   // Channel order inside packed triples: 0 red, 1 green, 2 blue
   localparam int unsigned NumChan = 3;
   localparam chan_type    FullAlpha = 8'd255;

   typedef enum logic [1:0] {
      CSR_CLARITY_ENABLE = 2'd0,
      CSR_CLARITY_LEVEL  = 2'd1,
      CSR_MASK_MODE      = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      MASK_NONE   = 2'd0,
      MASK_SINGLE = 2'd1,
      MASK_TRIPLE = 2'd2
   } mask_mode_type;

   typedef struct packed {
      logic          clarity_enable;
      chan_type      clarity_level;
      mask_mode_type mask_mode;
   } cfg_type;

   typedef struct packed {
      chan_type [NumChan-1:0] bg;
      chan_type [NumChan-1:0] fg;
      chan_type [NumChan-1:0] mask;
   } req_type;

   // Between clarity and mask halves: background, clarity result, mask alpha
   typedef struct packed {
      chan_type [NumChan-1:0] bg;
      chan_type [NumChan-1:0] t;
      chan_type [NumChan-1:0] alpha;
   } mid_type;

   // x*a + y*(255-a); never above 65025
   function automatic prod_type mac255(chan_type x, chan_type y, chan_type a);
      prod_type px;
      prod_type py;
      chan_type inv;
      begin
         inv = FullAlpha - a;
         px  = {8'd0, x} * {8'd0, a};
         py  = {8'd0, y} * {8'd0, inv};
         return px + py;
      end
   endfunction

   // floor(s/255), exact for s up to 65279, which covers every mac255 sum
   function automatic chan_type div255(prod_type s);
      logic [16:0] acc;
      begin
         acc = {1'b0, s} + 17'd1 + {9'd0, s[15:8]};
         return acc[15:8];
      end
   endfunction

endpackage

/* rtl/rac_req_if.sv */
// rac_req_if: input channel of the composer, background, foreground and mask bytes.
// Depends on nothing.

interface rac_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] bg_red;
   logic [7:0] bg_green;
   logic [7:0] bg_blue;
   logic [7:0] fg_red;
   logic [7:0] fg_green;
   logic [7:0] fg_blue;
   logic [7:0] mask_first;
   logic [7:0] mask_second;
   logic [7:0] mask_third;

   modport source (
      output valid, bg_red, bg_green, bg_blue, fg_red, fg_green, fg_blue,
             mask_first, mask_second, mask_third,
      input  ready
   );
   modport sink (
      input  valid, bg_red, bg_green, bg_blue, fg_red, fg_green, fg_blue,
             mask_first, mask_second, mask_third,
      output ready
   );
endinterface

/* rtl/rac_rsp_if.sv */
// rac_rsp_if: result channel of the composer, one composed RGB pixel.
// Depends on nothing.

interface rac_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_red;
   logic [7:0] out_green;
   logic [7:0] out_blue;

   modport source (output valid, out_red, out_green, out_blue, input ready);
   modport sink   (input valid, out_red, out_green, out_blue, output ready);
endinterface

/* rtl/rgb_alpha_compose.sv */
// rgb_alpha_compose: top level of the RGB alpha composer, four-stage pipeline.
// Depends on rac_pkg, rac_req_if, rac_rsp_if, rac_csr, rac_clarity, rac_mask.
//
//   channel   direction  handshake             payload
//   req_bus   in         valid/ready           bg_*, fg_*, mask_first/second/third
//   rsp_bus   out        valid/ready           out_red, out_green, out_blue
//   csr_*     in         csr_write_enable      csr_index, csr_write_data
//
// One pixel per clock while rsp_bus is ready; a result passes the clarity multiply,
// divide, mask multiply and divide registers in that order before it is offered.
// Synchronous reset clears the stage valid bits and loads the register defaults.
// Each stage holds while the next is full and stalled; ready is formed per stage,
// so bubbles close up and req_bus.ready stays high while a stage is free.

module rgb_alpha_compose (
   input  logic       clock,
   input  logic       reset,
   rac_req_if.sink    req_bus,
   rac_rsp_if.source  rsp_bus,
   input  logic       csr_write_enable,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_write_data
);

   rac_pkg::cfg_type                             cfg;
   rac_pkg::req_type                             req_data;
   rac_pkg::mid_type                             mid_data;
   logic                                         mid_valid;
   logic                                         mid_ready;
   rac_pkg::chan_type [rac_pkg::NumChan-1:0]     pixel;

   assign req_data.bg   = {req_bus.bg_blue, req_bus.bg_green, req_bus.bg_red};
   assign req_data.fg   = {req_bus.fg_blue, req_bus.fg_green, req_bus.fg_red};
   assign req_data.mask = {req_bus.mask_third, req_bus.mask_second, req_bus.mask_first};

   rac_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   rac_clarity u_clarity (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_bus.valid),
      .in_ready  (req_bus.ready),
      .in_data   (req_data),
      .out_valid (mid_valid),
      .out_ready (mid_ready),
      .out_data  (mid_data)
   );

   rac_mask u_mask (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mid_valid),
      .in_ready  (mid_ready),
      .in_data   (mid_data),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_pixel (pixel)
   );

   assign rsp_bus.out_red   = pixel[0];
   assign rsp_bus.out_green = pixel[1];
   assign rsp_bus.out_blue  = pixel[2];

endmodule

/* rtl/rac_csr.sv */
// rac_csr: configuration registers of the composer.
// Depends on rac_pkg.

module rac_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [1:0]           csr_index,
   input  logic [7:0]           csr_write_data,
   output rac_pkg::cfg_type     cfg
);

   rac_pkg::cfg_type cfg_ff;
   rac_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (rac_pkg::csr_index_type'(csr_index))
            rac_pkg::CSR_CLARITY_ENABLE: cfg_in.clarity_enable = csr_write_data[0];
            rac_pkg::CSR_CLARITY_LEVEL:  cfg_in.clarity_level  = csr_write_data;
            rac_pkg::CSR_MASK_MODE:
               cfg_in.mask_mode = rac_pkg::mask_mode_type'(csr_write_data[1:0]);
            default: ;  // unknown index: ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.clarity_enable <= 1'b0;
         cfg_ff.clarity_level  <= rac_pkg::FullAlpha;
         cfg_ff.mask_mode      <= rac_pkg::MASK_NONE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/rac_clarity.sv */
// rac_clarity: stages 1 and 2, clarity blend t = blend(fg, bg, level) and mask resolve.
// Depends on rac_pkg.

module rac_clarity (
   input  logic                 clock,
   input  logic                 reset,
   input  rac_pkg::cfg_type     cfg,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  rac_pkg::req_type     in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output rac_pkg::mid_type     out_data
);

   localparam int unsigned NumChan = rac_pkg::NumChan;

   logic                                 v1_ff;
   logic                                 v2_ff;
   rac_pkg::prod_type [NumChan-1:0]      sum1_ff, sum1_in;
   rac_pkg::chan_type [NumChan-1:0]      bg1_ff;
   rac_pkg::chan_type [NumChan-1:0]      alpha1_ff, alpha1_in;
   rac_pkg::mid_type                     mid2_ff, mid2_in;
   rac_pkg::chan_type                    level;
   logic                                 adv1;
   logic                                 adv2;

   assign adv2     = !v2_ff || out_ready;
   assign adv1     = !v1_ff || adv2;
   assign in_ready = adv1;

   // Clarity off: weight 255 on fg, which the divide returns unchanged
   assign level = cfg.clarity_enable ? cfg.clarity_level : rac_pkg::FullAlpha;

   always_comb begin
      for (int i = 0; i < NumChan; i++) begin
         sum1_in[i] = rac_pkg::mac255(in_data.fg[i], in_data.bg[i], level);
         case (cfg.mask_mode)
            rac_pkg::MASK_SINGLE: alpha1_in[i] = in_data.mask[0];
            rac_pkg::MASK_TRIPLE: alpha1_in[i] = in_data.mask[i];
            default:              alpha1_in[i] = 8'd0;  // alpha 0 passes t through
         endcase
      end
   end

   always_comb begin
      mid2_in.bg    = bg1_ff;
      mid2_in.alpha = alpha1_ff;
      for (int i = 0; i < NumChan; i++) begin
         mid2_in.t[i] = rac_pkg::div255(sum1_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= in_valid;
         if (adv2) v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1 && in_valid) begin
         sum1_ff   <= sum1_in;
         bg1_ff    <= in_data.bg;
         alpha1_ff <= alpha1_in;
      end
      if (adv2 && v1_ff) begin
         mid2_ff <= mid2_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_data  = mid2_ff;

endmodule

/* rtl/rac_mask.sv */
// rac_mask: stages 3 and 4, mask blend blend(bg, t, alpha) and output register.
// Depends on rac_pkg.

module rac_mask (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  rac_pkg::mid_type                      in_data,
   output logic                                  out_valid,
   input  logic                                  out_ready,
   output rac_pkg::chan_type [rac_pkg::NumChan-1:0] out_pixel
);

   localparam int unsigned NumChan = rac_pkg::NumChan;

   logic                                 v3_ff;
   logic                                 v4_ff;
   rac_pkg::prod_type [NumChan-1:0]      sum3_ff, sum3_in;
   rac_pkg::chan_type [NumChan-1:0]      pix4_ff, pix4_in;
   logic                                 adv3;
   logic                                 adv4;

   assign adv4     = !v4_ff || out_ready;
   assign adv3     = !v3_ff || adv4;
   assign in_ready = adv3;

   always_comb begin
      for (int i = 0; i < NumChan; i++) begin
         sum3_in[i] = rac_pkg::mac255(in_data.bg[i], in_data.t[i], in_data.alpha[i]);
         pix4_in[i] = rac_pkg::div255(sum3_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (adv3) v3_ff <= in_valid;
         if (adv4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv3 && in_valid) sum3_ff <= sum3_in;
      if (adv4 && v3_ff)    pix4_ff <= pix4_in;
   end

   assign out_valid = v4_ff;
   assign out_pixel = pix4_ff;

endmodule

/* verif/rac_pixel_checker.sv */
`timescale 1ns / 100ps
// rac_pixel_checker: passive checker for the RGB alpha composer. Tracks register
// writes, predicts each composed pixel and compares it with the result channel.
// Depends on rac_pkg, rac_req_if and rac_rsp_if.

module rac_pixel_checker
   import rac_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   rac_req_if         req_bus,
   rac_rsp_if         rsp_bus,
   input  logic       csr_write_enable,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_write_data,
   output int         fail_count,
   output int         expected_left
);

   typedef chan_type [NumChan-1:0] pixel_type;

   cfg_type   blend_cfg;
   pixel_type composed_q[$];
   string     chan_name[NumChan] = '{"red", "green", "blue"};

   initial begin
      fail_count    = 0;
      expected_left = 0;
   end

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $time, what);
      fail_count++;
   endtask

   // floor((x*a + y*(255-a)) / 255)
   function automatic chan_type weigh(chan_type x, chan_type y, chan_type a);
      int unsigned s;
      s = int'(x) * int'(a) + int'(y) * (int'(FullAlpha) - int'(a));
      return chan_type'(s / int'(FullAlpha));
   endfunction

   function automatic pixel_type composite_pixel(req_type item, cfg_type c);
      pixel_type px;
      chan_type  t;
      chan_type  alpha;
      bit        masked;
      masked = (c.mask_mode == MASK_SINGLE) || (c.mask_mode == MASK_TRIPLE);
      for (int ch = 0; ch < NumChan; ch++) begin
         t = c.clarity_enable ? weigh(item.fg[ch], item.bg[ch], c.clarity_level) : item.fg[ch];
         // single mask byte serves all channels unless per-channel mode
         alpha = (c.mask_mode == MASK_TRIPLE) ? item.mask[ch] : item.mask[0];
         px[ch] = masked ? weigh(item.bg[ch], t, alpha) : t;
      end
      return px;
   endfunction

   always @(posedge clock) begin : watch
      req_type   item;
      pixel_type got;
      pixel_type want;
      if (reset) begin
         blend_cfg.clarity_enable = 1'b0;
         blend_cfg.clarity_level  = FullAlpha;
         blend_cfg.mask_mode      = MASK_NONE;
         composed_q.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_CLARITY_ENABLE: blend_cfg.clarity_enable = csr_write_data[0];
               CSR_CLARITY_LEVEL:  blend_cfg.clarity_level  = csr_write_data;
               CSR_MASK_MODE:      blend_cfg.mask_mode = mask_mode_type'(csr_write_data[1:0]);
               default: ;
            endcase
         end
         if (req_bus.valid && req_bus.ready) begin
            item.bg[0]   = req_bus.bg_red;
            item.bg[1]   = req_bus.bg_green;
            item.bg[2]   = req_bus.bg_blue;
            item.fg[0]   = req_bus.fg_red;
            item.fg[1]   = req_bus.fg_green;
            item.fg[2]   = req_bus.fg_blue;
            item.mask[0] = req_bus.mask_first;
            item.mask[1] = req_bus.mask_second;
            item.mask[2] = req_bus.mask_third;
            composed_q.push_back(composite_pixel(item, blend_cfg));
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got[0] = rsp_bus.out_red;
            got[1] = rsp_bus.out_green;
            got[2] = rsp_bus.out_blue;
            if (composed_q.size() == 0) begin
               report_mismatch($sformatf("unexpected pixel %0d/%0d/%0d",
                                         got[0], got[1], got[2]));
            end else begin
               want = composed_q.pop_front();
               for (int ch = 0; ch < NumChan; ch++) begin
                  if (got[ch] !== want[ch])
                     report_mismatch($sformatf("%s got %0d expected %0d",
                                               chan_name[ch], got[ch], want[ch]));
               end
            end
         end
      end
      expected_left <= composed_q.size();
   end

endmodule

/* verif/rgb_alpha_compose_tb.sv */
`timescale 1ns / 100ps
// rgb_alpha_compose_tb: drives pixel transactions and register writes into the
// composer under several throttling phases. Depends on rac_pkg, the channel
// interfaces, rgb_alpha_compose and rac_pixel_checker.

module rgb_alpha_compose_tb;
   import rac_pkg::*;

   localparam int         CycleLimit      = 200000;
   localparam int         LongHoldCycles  = 150;
   localparam int         PhaseItems      = 150;
   localparam logic [1:0] CSR_INDEX_SPARE = 2'd3;
   localparam logic [1:0] MASK_SPARE      = 2'd3;

   logic       clock = 1'b0;
   logic       reset;
   logic       csr_write_enable;
   logic [1:0] csr_index;
   logic [7:0] csr_write_data;
   int         fail_count;
   int         expected_left;
   int         req_idle_pct  = 0;
   int         rsp_stall_pct = 0;
   int         hold_seq      = 0;
   int         cycle_count   = 0;

   rac_req_if req_bus ();
   rac_rsp_if rsp_bus ();

   rgb_alpha_compose DUT (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   rac_pixel_checker pixel_check (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .expected_left    (expected_left)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("FAIL");
         $finish;
      end
   end

   // result side: random stalls, plus a long hold-off whenever hold_seq moves
   initial begin : rsp_side
      int hold_seen;
      int hold_left;
      hold_seen = 0;
      hold_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_left = LongHoldCycles;
         end
         if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
         end
      end
   end

   // extremes turn up often so that saturating cases get plenty of hits
   function automatic chan_type rand_byte();
      case ($urandom_range(0, 7))
         0: return 8'd0;
         1: return 8'd255;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic req_type rand_pixel();
      req_type px;
      for (int ch = 0; ch < NumChan; ch++) begin
         px.bg[ch]   = rand_byte();
         px.fg[ch]   = rand_byte();
         px.mask[ch] = rand_byte();
      end
      return px;
   endfunction

   function automatic req_type make_px(chan_type br, chan_type bgr, chan_type bb,
                                       chan_type fr, chan_type fgr, chan_type fb,
                                       chan_type m0, chan_type m1, chan_type m2);
      req_type px;
      px.bg   = {bb, bgr, br};
      px.fg   = {fb, fgr, fr};
      px.mask = {m2, m1, m0};
      return px;
   endfunction

   task automatic send_pixel(input req_type px);
      while (req_idle_pct != 0 && $urandom_range(0, 99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.bg_red      <= px.bg[0];
      req_bus.bg_green    <= px.bg[1];
      req_bus.bg_blue     <= px.bg[2];
      req_bus.fg_red      <= px.fg[0];
      req_bus.fg_green    <= px.fg[1];
      req_bus.fg_blue     <= px.fg[2];
      req_bus.mask_first  <= px.mask[0];
      req_bus.mask_second <= px.mask[1];
      req_bus.mask_third  <= px.mask[2];
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // wait for the pipeline to drain, then wait out the extra cycles given by the caller
   task automatic settle(input int extra);
      do @(posedge clock); while (expected_left != 0);
      repeat (extra) @(posedge clock);
   endtask

   // upper data bits are junk on purpose; the spare index must be ignored
   task automatic load_config(input logic en, input chan_type lvl, input logic [1:0] mode);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_CLARITY_ENABLE;
      csr_write_data   <= {7'($urandom), en};
      @(posedge clock);
      csr_index      <= CSR_CLARITY_LEVEL;
      csr_write_data <= lvl;
      @(posedge clock);
      csr_index      <= CSR_MASK_MODE;
      csr_write_data <= {6'($urandom), mode};
      @(posedge clock);
      csr_index      <= CSR_INDEX_SPARE;
      csr_write_data <= 8'($urandom);
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic run_directed();
      send_pixel(make_px(0, 0, 0, 255, 255, 255, 0, 0, 0));
      send_pixel(make_px(255, 255, 255, 0, 0, 0, 255, 255, 255));
      send_pixel(make_px(0, 0, 0, 255, 255, 255, 255, 0, 128));
      send_pixel(make_px(255, 255, 255, 255, 255, 255, 255, 255, 255));
      send_pixel(make_px(0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_pixel(make_px(12, 200, 77, 250, 3, 128, 1, 254, 127));
      send_pixel(make_px(255, 0, 255, 0, 255, 0, 128, 127, 129));
      send_pixel(rand_pixel());
      req_bus.valid <= 1'b0;
   endtask

   task automatic run_phase(input logic en, input chan_type lvl, input logic [1:0] mode,
                            input int req_pct, input int rsp_pct, input bit long_hold);
      settle(6);
      load_config(en, lvl, mode);
      req_idle_pct  <= req_pct;
      rsp_stall_pct <= rsp_pct;
      if (long_hold)
         hold_seq <= hold_seq + 1;
      repeat (PhaseItems) send_pixel(rand_pixel());
      req_bus.valid <= 1'b0;
   endtask

   initial begin : stimulus
      reset               <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.bg_red      <= '0;
      req_bus.bg_green    <= '0;
      req_bus.bg_blue     <= '0;
      req_bus.fg_red      <= '0;
      req_bus.fg_green    <= '0;
      req_bus.fg_blue     <= '0;
      req_bus.mask_first  <= '0;
      req_bus.mask_second <= '0;
      req_bus.mask_third  <= '0;
      csr_write_enable    <= 1'b0;
      csr_index           <= CSR_CLARITY_ENABLE;
      csr_write_data      <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // register defaults first, then clarity level 0 with triple masks and level 128 with a single mask
      run_directed();
      settle(6);
      load_config(1'b1, 8'd0, MASK_TRIPLE);
      run_directed();
      settle(6);
      load_config(1'b1, 8'd128, MASK_SINGLE);
      run_directed();

      run_phase(1'b0, rand_byte(), MASK_NONE,   0,  0,  1'b0);
      run_phase(1'b1, 8'd255,      MASK_TRIPLE, 87, 0,  1'b0);
      run_phase(1'b1, 8'd0,        MASK_SINGLE, 0,  87, 1'b0);
      run_phase(1'b1, rand_byte(), MASK_TRIPLE, 28, 28, 1'b0);
      run_phase(1'b0, rand_byte(), MASK_SINGLE, 0,  0,  1'b1);
      run_phase(1'b1, rand_byte(), MASK_SPARE,  87, 0,  1'b0);
      run_phase(1'b1, 8'd1,        MASK_TRIPLE, 0,  87, 1'b0);
      run_phase(1'b0, 8'd254,      MASK_TRIPLE, 28, 28, 1'b0);

      settle(10);
      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

/* rgb_alpha_compose.f */
rtl/rac_pkg.sv
rtl/rac_req_if.sv
rtl/rac_rsp_if.sv
rtl/rac_csr.sv
rtl/rac_clarity.sv
rtl/rac_mask.sv
rtl/rgb_alpha_compose.sv
verif/rac_pixel_checker.sv
verif/rgb_alpha_compose_tb.sv
